/* hw/rtl/lpr_pkg.sv */
// Shared widths, register indexes and control structs for the line rasterizer.
package lpr_pkg;

	localparam int CoordW  = 6;
	localparam int SideW   = 7;
	localparam int ColorW  = 8;
	localparam int AddrW   = 12;
	localparam int ErrW    = 9;
	localparam int CfgIdxW = 2;
	localparam int MaxSide = 64;

	localparam logic [SideW-1:0] MAX_SIDE_V = SideW'(MaxSide);

	localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = CfgIdxW'(1);

	typedef struct packed {
		logic load;
		logic step;
	} lpr_cmd_t;

	typedef struct packed {
		logic out_free;
		logic done;
	} lpr_status_t;

endpackage

/* hw/rtl/lpr_ctrl.sv */
// Controller state machine: takes a line transaction and steps the walk.
module lpr_ctrl import lpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  lpr_status_t status,
	output lpr_cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;

	assign in_ready = (state_q == ST_IDLE);
	assign cmd.load = in_valid && in_ready;
	assign cmd.step = (state_q == ST_RUN) && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.step && status.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_load_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_RUN))
		else $error("load did not start a walk");

	a_step_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !in_ready)
		else $error("step while taking input");

endmodule

/* hw/rtl/lpr_datapath.sv */
// Datapath: frame registers, Bresenham error term, address and output register.
module lpr_datapath import lpr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lpr_cmd_t           cmd,
	output lpr_status_t        status,
	input  logic               cfg_valid,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [SideW-1:0]   cfg_data,
	input  logic [CoordW-1:0]  start_x,
	input  logic [CoordW-1:0]  start_y,
	input  logic [CoordW-1:0]  end_x,
	input  logic [CoordW-1:0]  end_y,
	input  logic [ColorW-1:0]  line_color,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CoordW-1:0]  point_x,
	output logic [CoordW-1:0]  point_y,
	output logic [AddrW-1:0]   write_address,
	output logic [ColorW-1:0]  pixel_color,
	output logic               inside_res,
	output logic               last
);

	logic [SideW-1:0]  width_q, height_q;
	logic [CoordW-1:0] x_q, y_q, xe_q, ye_q, dx_q, dy_q;
	logic              sx_neg_q, sy_neg_q;
	logic signed [ErrW-1:0] err_q;
	logic [ColorW-1:0] color_q;

	logic              out_valid_q;
	logic [CoordW-1:0] point_x_q, point_y_q;
	logic [AddrW-1:0]  addr_q;
	logic [ColorW-1:0] pixel_color_q;
	logic              inside_q, last_q;

	logic [SideW-1:0]  w_eff, h_eff, row_full;
	logic [CoordW-1:0] dx_in, dy_in, row;
	logic              in_frame, done, step_x, step_y;
	logic [CoordW+SideW-1:0] prod;
	logic [AddrW-1:0]  addr;
	logic signed [ErrW:0]   e2, dx_s, dy_s;
	logic signed [ErrW-1:0] err_next;

	always_comb begin
		w_eff    = (width_q > MAX_SIDE_V) ? MAX_SIDE_V : width_q;
		h_eff    = (height_q > MAX_SIDE_V) ? MAX_SIDE_V : height_q;
		in_frame = ({1'b0, x_q} < w_eff) && ({1'b0, y_q} < h_eff);
		row_full = h_eff - SideW'(1) - {1'b0, y_q};
		row      = row_full[CoordW-1:0];
		prod     = row * w_eff;
		addr     = in_frame ? (AddrW'(prod) + AddrW'(x_q)) : '0;
		done     = (x_q == xe_q) && (y_q == ye_q);

		dx_in = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
		dy_in = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);

		e2     = {err_q, 1'b0};
		dx_s   = $signed({{(ErrW+1-CoordW){1'b0}}, dx_q});
		dy_s   = $signed({{(ErrW+1-CoordW){1'b0}}, dy_q});
		step_x = (e2 + dy_s) > $signed((ErrW+1)'(0));
		step_y = e2 < dx_s;
		err_next = err_q - (step_x ? $signed(dy_s[ErrW-1:0]) : $signed(ErrW'(0)))
			+ (step_y ? $signed(dx_s[ErrW-1:0]) : $signed(ErrW'(0)));
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign status.done     = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= MAX_SIDE_V;
			height_q <= MAX_SIDE_V;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_FRAME_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == CFG_FRAME_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= start_x;
			y_q      <= start_y;
			xe_q     <= end_x;
			ye_q     <= end_y;
			dx_q     <= dx_in;
			dy_q     <= dy_in;
			sx_neg_q <= !(start_x < end_x);
			sy_neg_q <= !(start_y < end_y);
			err_q    <= $signed({3'b000, dx_in}) - $signed({3'b000, dy_in});
			color_q  <= line_color;
		end else if (cmd.step) begin
			if (step_x) begin
				x_q <= sx_neg_q ? (x_q - CoordW'(1)) : (x_q + CoordW'(1));
			end
			if (step_y) begin
				y_q <= sy_neg_q ? (y_q - CoordW'(1)) : (y_q + CoordW'(1));
			end
			err_q <= err_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			point_x_q     <= x_q;
			point_y_q     <= y_q;
			addr_q        <= addr;
			pixel_color_q <= color_q;
			inside_q      <= in_frame;
			last_q        <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign point_x       = point_x_q;
	assign point_y       = point_y_q;
	assign write_address = addr_q;
	assign pixel_color   = pixel_color_q;
	assign inside_res    = inside_q;
	assign last          = last_q;

	a_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> out_valid_q)
		else $error("stepped point not presented");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !inside_q) |-> (addr_q == '0))
		else $error("outside point carries an address");

endmodule

/* hw/rtl/line_pixel_rasterizer.sv */
// Top level of the Bresenham line rasterizer: controller plus datapath.
// A line transaction is accepted in the idle state and then yields one point per cycle
// while the output does not stall, max(|end_x-start_x|, |end_y-start_y|) + 1 points in
// all (1 to 64); the error-term update loop in the datapath paces the points and each
// output stall holds the walk. The next line is taken once the last point has moved into
// the output register.
module line_pixel_rasterizer import lpr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [SideW-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CoordW-1:0]  start_x,
	input  logic [CoordW-1:0]  start_y,
	input  logic [CoordW-1:0]  end_x,
	input  logic [CoordW-1:0]  end_y,
	input  logic [ColorW-1:0]  line_color,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CoordW-1:0]  point_x,
	output logic [CoordW-1:0]  point_y,
	output logic [AddrW-1:0]   write_address,
	output logic [ColorW-1:0]  pixel_color,
	output logic               inside_res,
	output logic               last
);

	lpr_cmd_t    cmd;
	lpr_status_t status;

	assign cfg_ready = 1'b1;

	lpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lpr_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.line_color    (line_color),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.point_x       (point_x),
		.point_y       (point_y),
		.write_address (write_address),
		.pixel_color   (pixel_color),
		.inside_res    (inside_res),
		.last          (last)
	);

endmodule

/* dv/tb_top.sv */
// Self-checking line rasterizer bench: directed and random lines, set frames vs. point model.
module tb_top;
	import lpr_pkg::*;

	localparam int IdlePct       = 16;
	localparam int ReportLimit   = 10;
	localparam int WatchdogLimit = 2000;
	localparam int SettleCycles  = 4;
	localparam int TailCycles    = 20;

	localparam logic [CfgIdxW-1:0] CFG_SPARE_A = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] CFG_SPARE_B = CfgIdxW'(3);

	typedef struct packed {
		logic [CoordW-1:0] sx;
		logic [CoordW-1:0] sy;
		logic [CoordW-1:0] ex;
		logic [CoordW-1:0] ey;
		logic [ColorW-1:0] color;
	} line_t;

	typedef struct packed {
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [AddrW-1:0]  addr;
		logic [ColorW-1:0] color;
		logic              in_frame;
		logic              is_last;
	} point_t;

	class line_scoreboard;
		point_t owed[$];
		int     frame_w;
		int     frame_h;
		int     mismatches;
		int     lines_noted;
		int     points_checked;

		function new();
			frame_w = MaxSide;
			frame_h = MaxSide;
			mismatches = 0;
			lines_noted = 0;
			points_checked = 0;
		endfunction

		function void note_reg(logic [CfgIdxW-1:0] idx, logic [SideW-1:0] data);
			if (idx == CFG_FRAME_WIDTH) begin
				frame_w = int'(data);
			end else if (idx == CFG_FRAME_HEIGHT) begin
				frame_h = int'(data);
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// walk the line with the all-octant error term, one point per step
		function void note_line(line_t ln);
			int x, y, xe, ye, dx, dy, stx, sty, err, e2, w, h;
			bit done;
			point_t p;
			x = int'(ln.sx);
			y = int'(ln.sy);
			xe = int'(ln.ex);
			ye = int'(ln.ey);
			dx = (xe > x) ? xe - x : x - xe;
			dy = (ye > y) ? ye - y : y - ye;
			stx = (x < xe) ? 1 : -1;
			sty = (y < ye) ? 1 : -1;
			err = dx - dy;
			w = (frame_w > MaxSide) ? MaxSide : frame_w;
			h = (frame_h > MaxSide) ? MaxSide : frame_h;
			lines_noted++;
			repeat (MaxSide) begin
				done = (x == xe) && (y == ye);
				p.x = CoordW'(x);
				p.y = CoordW'(y);
				p.in_frame = (x < w) && (y < h);
				p.addr = p.in_frame ? AddrW'((h - 1 - y) * w + x) : '0;
				p.color = ln.color;
				p.is_last = done;
				owed.push_back(p);
				if (done) begin
					break;
				end
				e2 = 2 * err;
				if (e2 > -dy) begin
					err -= dy;
					x += stx;
				end
				if (e2 < dx) begin
					err += dx;
					y += sty;
				end
			end
		endfunction

		function void check_point(point_t got);
			point_t want;
			points_checked++;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportLimit) begin
					$display("unexpected point x=%0d y=%0d with no line pending", got.x, got.y);
				end
				return;
			end
			want = owed.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= ReportLimit) begin
					$display("point mismatch: expected x=%0d y=%0d addr=%0d color=%0d in=%0b last=%0b",
						want.x, want.y, want.addr, want.color, want.in_frame, want.is_last);
					$display("                got      x=%0d y=%0d addr=%0d color=%0d in=%0b last=%0b",
						got.x, got.y, got.addr, got.color, got.in_frame, got.is_last);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [SideW-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [CoordW-1:0]  start_x = '0;
	logic [CoordW-1:0]  start_y = '0;
	logic [CoordW-1:0]  end_x = '0;
	logic [CoordW-1:0]  end_y = '0;
	logic [ColorW-1:0]  line_color = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [CoordW-1:0]  point_x;
	logic [CoordW-1:0]  point_y;
	logic [AddrW-1:0]   write_address;
	logic [ColorW-1:0]  pixel_color;
	logic               inside_res;
	logic               last;

	logic           calm = 1'b0;
	int             stall_cycles = 0;
	int             settings_used = 1;
	line_scoreboard sb = new();

	line_pixel_rasterizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.line_color   (line_color),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_x      (point_x),
		.point_y      (point_y),
		.write_address(write_address),
		.pixel_color  (pixel_color),
		.inside_res   (inside_res),
		.last         (last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				sb.check_point({point_x, point_y, write_address, pixel_color, inside_res, last});
			end
			out_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
			|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WatchdogLimit) begin
			$display("watchdog: no transaction for %0d cycles", stall_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic line_t mk_line(int sx, int sy, int ex, int ey, int color);
		line_t ln;
		ln.sx = CoordW'(sx);
		ln.sy = CoordW'(sy);
		ln.ex = CoordW'(ex);
		ln.ey = CoordW'(ey);
		ln.color = ColorW'(color);
		return ln;
	endfunction

	task automatic send_line(input line_t ln);
		while (!calm && $urandom_range(0, 99) < IdlePct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_x <= ln.sx;
		start_y <= ln.sy;
		end_x <= ln.ex;
		end_y <= ln.ey;
		line_color <= ln.color;
		do @(posedge clk); while (!in_ready);
		sb.note_line(ln);
	endtask

	task automatic send_random_line();
		line_t ln;
		int shape;
		shape = $urandom_range(0, 9);
		ln = mk_line($urandom, $urandom, $urandom, $urandom, $urandom);
		unique case (shape)
			0, 1: begin
				ln.ex = ln.sx ^ CoordW'($urandom_range(0, 3));
				ln.ey = ln.sy ^ CoordW'($urandom_range(0, 3));
			end
			2: ln.ey = ln.sy;
			3: ln.ex = ln.sx;
			4: begin
				ln.sy = ln.sx;
				ln.ey = ln.ex;
			end
			5: begin
				ln.sy = ~ln.sx;
				ln.ey = ~ln.ex;
			end
			6: begin
				ln.ex = ln.sx;
				ln.ey = ln.sy;
			end
			default: ;
		endcase
		send_line(ln);
	endtask

	// hold input, drain every owed point, then let the block settle
	task automatic quiesce();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SideW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.note_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(input int w, input int h);
		quiesce();
		write_reg(CFG_FRAME_WIDTH, SideW'(w));
		write_reg(CFG_FRAME_HEIGHT, SideW'(h));
		settings_used++;
	endtask

	task automatic random_lines(input int count, input bit steady);
		calm <= steady;
		repeat (count) send_random_line();
		calm <= 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_line(mk_line(0, 0, 0, 0, 0));
		send_line(mk_line(63, 63, 63, 63, 255));
		send_line(mk_line(0, 0, 63, 0, 'hAA));
		send_line(mk_line(0, 63, 0, 0, 'h55));
		send_line(mk_line(0, 0, 63, 63, 1));
		send_line(mk_line(63, 0, 0, 63, 128));
		send_line(mk_line(32, 32, 40, 35, 2));
		send_line(mk_line(32, 32, 35, 40, 3));
		send_line(mk_line(32, 32, 29, 40, 4));
		send_line(mk_line(32, 32, 24, 35, 5));
		send_line(mk_line(32, 32, 24, 29, 6));
		send_line(mk_line(32, 32, 29, 24, 7));
		send_line(mk_line(32, 32, 35, 24, 8));
		send_line(mk_line(32, 32, 40, 29, 9));
		random_lines(10, 1'b0);

		set_frame(1, 1);
		send_line(mk_line(0, 0, 3, 2, 'h0F));
		send_line(mk_line(2, 5, 0, 0, 'hF0));
		random_lines(15, 1'b0);

		set_frame(0, 0);
		send_line(mk_line(0, 0, 5, 5, 'h3C));
		random_lines(10, 1'b0);

		// saturated frame size, random lines run with no idling on either side
		set_frame(127, 100);
		send_line(mk_line(63, 63, 0, 60, 'hC3));
		send_line(mk_line(0, 0, 63, 63, 255));
		random_lines(20, 1'b1);

		set_frame(17, 9);
		random_lines(10, 1'b0);

		quiesce();
		write_reg(CFG_SPARE_A, SideW'(127));
		write_reg(CFG_SPARE_B, SideW'(0));
		write_reg(CFG_FRAME_HEIGHT, SideW'(37));
		settings_used++;
		random_lines(10, 1'b0);

		set_frame(5, 64);
		random_lines(10, 1'b0);

		set_frame(64, 1);
		random_lines(10, 1'b0);

		set_frame(64, 64);
		random_lines(15, 1'b0);

		quiesce();
		repeat (TailCycles) @(posedge clk);

		$display("covered %0d lines and %0d points over %0d frame settings,",
			sb.lines_noted, sb.points_checked, settings_used);
		$display("including zero, one-pixel and saturated frames and ignored register indexes");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches, %0d points still owed", sb.mismatches, sb.pending());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
